@@ hw/rtl/isr_pkg.sv @@
package isr_pkg;

  // operand width, root digits and internal datapath widths
  localparam int INPUT_BITS    = 31;
  localparam int ROOT_BITS     = (INPUT_BITS + 1) / 2;
  localparam int ACC_BITS      = 2 * ROOT_BITS + 1;
  localparam int ROOT_OUT_BITS = 16;

  // probe weight for the most significant root digit
  localparam logic [ACC_BITS-1:0] TOP_PROBE = ACC_BITS'(1) << (2 * (ROOT_BITS - 1));

  // what one cell hands to the next
  typedef struct packed {
    logic                  valid;
    logic [INPUT_BITS-1:0] rem;
    logic [ACC_BITS-1:0]   acc;
    logic [ACC_BITS-1:0]   probe;
  } isr_stage_t;

endpackage

@@ hw/rtl/isr_cell.sv @@
module isr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  isr_pkg::isr_stage_t stg_in,
  output isr_pkg::isr_stage_t stg_out
);
  import isr_pkg::*;

  logic [ACC_BITS-1:0]   trial;
  logic                  fits;
  logic [INPUT_BITS-1:0] rem_nxt;
  logic [ACC_BITS-1:0]   acc_nxt;
  logic [ACC_BITS-1:0]   probe_nxt;
  logic                  valid_r;
  logic [INPUT_BITS-1:0] rem_r;
  logic [ACC_BITS-1:0]   acc_r;
  logic [ACC_BITS-1:0]   probe_r;

  // decide one root digit: subtract the trial if it fits
  always_comb begin
    trial     = stg_in.acc + stg_in.probe;
    fits      = ACC_BITS'(stg_in.rem) >= trial;
    probe_nxt = stg_in.probe >> 2;
    if (fits) begin
      rem_nxt = stg_in.rem - trial[INPUT_BITS-1:0];
      acc_nxt = (stg_in.acc >> 1) + stg_in.probe;
    end else begin
      rem_nxt = stg_in.rem;
      acc_nxt = stg_in.acc >> 1;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= stg_in.valid;
    end
  end

  // partial remainder and root
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r   <= rem_nxt;
      acc_r   <= acc_nxt;
      probe_r <= probe_nxt;
    end
  end

  assign stg_out.valid = valid_r;
  assign stg_out.rem   = rem_r;
  assign stg_out.acc   = acc_r;
  assign stg_out.probe = probe_r;

endmodule

@@ hw/rtl/integer_square_root.sv @@
// Integer square root: returns floor(sqrt(value)) for an unsigned operand.
// Input channel: in_valid / in_stall with payload in_value. A beat is taken
// on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with payload out_root, one result
// beat for every input beat, in the same order.
// The datapath is a row of ROOT_BITS identical cells (16 for a 31-bit
// operand); each cell decides one root digit with one compare-and-subtract
// and registers its partial remainder and root for the next cell.
// Each beat passes through the registers of all cells in turn. Throughput
// is one beat per cycle unless out_stall holds the row: the row advances
// as a whole; a new operand enters while earlier ones still move down it.
// The last cell is the output register. While out_valid is high and
// out_stall is high the whole row holds and in_stall is raised; the result
// stays on out_root unchanged until taken.
// Reset (rst_n low, synchronous) empties the row; no state carries over
// from one operand to the next.
module integer_square_root (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [isr_pkg::INPUT_BITS-1:0]    in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [isr_pkg::ROOT_OUT_BITS-1:0] out_root
);
  import isr_pkg::*;

  isr_stage_t stg [ROOT_BITS+1];
  logic       adv;

  // the row moves unless a finished beat is held up at the output
  assign adv      = !(stg[ROOT_BITS].valid && out_stall);
  assign in_stall = !adv;

  // feed of the first cell
  assign stg[0].valid = in_valid;
  assign stg[0].rem   = in_value;
  assign stg[0].acc   = '0;
  assign stg[0].probe = TOP_PROBE;

  // one cell per root digit
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
    isr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stg_in  (stg[i]),
      .stg_out (stg[i+1])
    );
  end

  // result beat
  assign out_valid = stg[ROOT_BITS].valid;
  assign out_root  = ROOT_OUT_BITS'(stg[ROOT_BITS].acc);

endmodule
